// ===== hw/rtl/jse_pkg.sv =====
`timescale 1ns / 1ps
// jse_pkg: shared types, character constants and escape helpers for the json string escaper
// no dependencies; used by jse_front, jse_queue, jse_back and json_string_escape

package jse_pkg;

   // register index on the csr port (byte address 4 * index)
   localparam logic REG_OUT_CAPACITY = 1'b0;
   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   // characters
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic [2:0] UNI_LEN = 3'd6;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_ESC2,
      KIND_UNI,
      KIND_TERM
   } kind_type;

   // one classified request as it travels from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [2:0] len;
   } desc_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'd0, d};
      end else begin
         r = CHAR_LOWER_A + {4'd0, d} - 8'd10;
      end
      return r;
   endfunction

   // byte at position idx of the escaped form of a descriptor
   function automatic logic [7:0] seq_byte(input desc_type d, input logic [2:0] idx);
      logic [7:0] r;
      r = CHAR_NUL;
      case (d.kind)
         KIND_PASS: begin
            r = d.ch;
         end
         KIND_ESC2: begin
            r = (idx == 3'd0) ? CHAR_BACKSLASH : d.ch;
         end
         KIND_UNI: begin
            case (idx)
               3'd0: r = CHAR_BACKSLASH;
               3'd1: r = CHAR_LOWER_U;
               3'd2: r = CHAR_ZERO;
               3'd3: r = CHAR_ZERO;
               3'd4: r = hex_char(d.ch[7:4]);
               3'd5: r = hex_char(d.ch[3:0]);
               default: r = CHAR_NUL;
            endcase
         end
         KIND_TERM: begin
            r = CHAR_NUL;
         end
         default: r = CHAR_NUL;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/jse_front.sv =====
`timescale 1ns / 1ps
// jse_front: accepts requests, tracks the output count and classifies each byte
// depends on jse_pkg

module jse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic [15:0]        capacity,
   input  jse_pkg::qstat_type qstat,
   output logic               push,
   output jse_pkg::desc_type  push_desc,
   output logic [15:0]        out_count
);

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic        accept;
   logic [15:0] limit;
   logic        room_left;
   logic [15:0] room;
   logic        is_term;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign is_term   = (req_in_byte == jse_pkg::CHAR_NUL);
   assign limit     = (capacity >= 16'd2) ? (capacity - 16'd2) : 16'd0;
   assign room_left = (count_ff < limit);
   // valid only while room_left holds; at least two then
   assign room      = capacity - 16'd1 - count_ff;

   always_comb begin
      push_desc.kind = jse_pkg::KIND_PASS;
      push_desc.ch   = req_in_byte;
      push_desc.len  = 3'd1;
      if (is_term) begin
         push_desc.kind = jse_pkg::KIND_TERM;
         push_desc.ch   = jse_pkg::CHAR_NUL;
      end else if (req_in_byte == jse_pkg::CHAR_QUOTE
                   || req_in_byte == jse_pkg::CHAR_BACKSLASH) begin
         push_desc.kind = jse_pkg::KIND_ESC2;
         push_desc.len  = 3'd2;
      end else if (req_in_byte == jse_pkg::CHAR_LF) begin
         push_desc.kind = jse_pkg::KIND_ESC2;
         push_desc.ch   = jse_pkg::CHAR_LOWER_N;
         push_desc.len  = 3'd2;
      end else if (req_in_byte == jse_pkg::CHAR_CR) begin
         push_desc.kind = jse_pkg::KIND_ESC2;
         push_desc.ch   = jse_pkg::CHAR_LOWER_R;
         push_desc.len  = 3'd2;
      end else if (req_in_byte == jse_pkg::CHAR_TAB) begin
         push_desc.kind = jse_pkg::KIND_ESC2;
         push_desc.ch   = jse_pkg::CHAR_LOWER_T;
         push_desc.len  = 3'd2;
      end else if (req_in_byte < jse_pkg::CHAR_SPACE) begin
         // truncated so the terminator still fits
         push_desc.kind = jse_pkg::KIND_UNI;
         push_desc.len  = (room < 16'd6) ? room[2:0] : jse_pkg::UNI_LEN;
      end
   end

   assign push = accept && (is_term || room_left);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (is_term) begin
            count_in = 16'd0;
         end else if (room_left) begin
            count_in = count_ff + {13'd0, push_desc.len};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_count = count_ff;

endmodule

// ===== hw/rtl/jse_queue.sv =====
`timescale 1ns / 1ps
// jse_queue: short descriptor queue between front and back
// depends on jse_pkg

module jse_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jse_pkg::desc_type  push_desc,
   input  logic               pop,
   output jse_pkg::desc_type  head_desc,
   output jse_pkg::qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jse_pkg::desc_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign qstat.full  = (fill_ff == CNT_W'(DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign head_desc   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== hw/rtl/jse_back.sv =====
`timescale 1ns / 1ps
// jse_back: expands each descriptor into its escaped bytes, one per cycle while rsp_ready is high
// depends on jse_pkg

module jse_back (
   input  logic               clock,
   input  logic               reset,
   input  jse_pkg::desc_type  head_desc,
   input  jse_pkg::qstat_type qstat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_string
);

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       last_ff;
   logic       last_in;
   logic       eos_ff;
   logic       eos_in;
   logic       load;
   logic       at_last;

   assign load    = !qstat.empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head_desc.len - 3'd1);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      eos_in   = eos_ff;
      if (load) begin
         idx_in   = at_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
         byte_in  = jse_pkg::seq_byte(head_desc, idx_ff);
         last_in  = at_last;
         eos_in   = (head_desc.kind == jse_pkg::KIND_TERM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      eos_ff  <= eos_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_end_of_string = eos_ff;

endmodule

// ===== hw/rtl/json_string_escape.sv =====
`timescale 1ns / 1ps
// an accepted request, unless dropped, is queued first, and its first result then loads into the output register
// throughput: one request per cycle in while the queue has room; one result per cycle out
//   while rsp_ready is high, and a queued request expands to n escaped bytes (1 to 6)
// the back end's single output byte per cycle sets the sustained rate
// reset (synchronous, active high): capacity 256, output count 0, queue and output empty

module json_string_escape #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_string,
   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // capacity register and its write decode
   logic [15:0]        capacity_ff;
   logic [15:0]        capacity_in;
   logic               csr_write;
   logic               csr_hit;

   // front to queue
   logic               push;
   jse_pkg::desc_type  push_desc;
   logic [15:0]        out_count;

   // queue to back
   logic               pop;
   jse_pkg::desc_type  head_desc;
   jse_pkg::qstat_type qstat;

   // apb: always ready, write lands at the access phase
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == jse_pkg::REG_OUT_CAPACITY);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? {16'd0, capacity_ff} : 32'd0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_hit) begin
         capacity_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= jse_pkg::CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // front: count tracking, drop decision and classification
   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .capacity    (capacity_ff),
      .qstat       (qstat),
      .push        (push),
      .push_desc   (push_desc),
      .out_count   (out_count)
   );

   // short queue so front and back stall independently
   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .qstat     (qstat)
   );

   // back: byte sequencer with output register
   jse_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_desc         (head_desc),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

   // a terminator is a lone zero byte that closes its run
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_out_byte == 8'd0 && rsp_last_of_run)
      else $error("terminator result malformed");

   // escaped bytes are never zero
   a_no_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_string |-> rsp_out_byte != 8'd0)
      else $error("zero byte inside string");

   // a zero request clears the output count
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_in_byte == 8'd0 |=> out_count == 16'd0)
      else $error("terminator did not clear count");

   // a new result only comes from a queued request
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!qstat.empty))
      else $error("result without queued request");

endmodule

// ===== verif/json_string_escape_tb.sv =====
`timescale 1ns / 1ps
// json_string_escape_tb: self-checking bench for the json string escaper, directed then random
// depends on jse_pkg and json_string_escape from hw/rtl

module json_string_escape_tb;

   // longest run of cycles with no handshake and no csr access before we give up
   localparam int IDLE_LIMIT    = 2000;
   // settle time after the last result, covers a dropped request still in flight
   localparam int DRAIN_PAUSE   = 8;
   // random requests offered to the block, consumed or dropped
   localparam int RANDOM_TARGET = 250;

   // one escaped output byte as the result channel should present it
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       eos;
   } esc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_end_of_string;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // predictor state, mirrors the capacity register and the running output count
   logic [15:0]  capacity_shadow = jse_pkg::CAPACITY_RESET;
   logic [15:0]  count_shadow = 16'd0;
   esc_byte_type pending_escapes[$];

   // run statistics
   int error_count = 0;
   int sent_requests = 0;
   int useful_requests = 0;
   int dropped_requests = 0;
   int results_checked = 0;
   int strings_ended = 0;
   int capacity_writes = 0;
   int idle_cycles = 0;

   // idling controls, flipped per phase so some stretches run flat out
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int stall_left = 0;

   json_string_escape DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return jse_pkg::CHAR_ZERO + {4'd0, nib};
      end
      return jse_pkg::CHAR_LOWER_A + {4'd0, nib} - 8'd10;
   endfunction

   // work out the escaped bytes one accepted request should produce
   function automatic void predict_escape(input logic [7:0] c);
      logic [7:0] seq[6];
      int n;
      int lim;
      int room;
      int i;
      // terminator always goes out and restarts the count
      if (c == jse_pkg::CHAR_NUL) begin
         pending_escapes.push_back('{ch: jse_pkg::CHAR_NUL, last: 1'b1, eos: 1'b1});
         count_shadow = 16'd0;
         useful_requests++;
         strings_ended++;
         return;
      end
      // two slots are held back: one for an escape pair, one for the terminator
      lim = (int'(capacity_shadow) >= 2) ? int'(capacity_shadow) - 2 : 0;
      if (int'(count_shadow) >= lim) begin
         dropped_requests++;
         return;
      end
      useful_requests++;
      if (c == jse_pkg::CHAR_QUOTE || c == jse_pkg::CHAR_BACKSLASH) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = c;
         n = 2;
      end else if (c == jse_pkg::CHAR_LF) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = jse_pkg::CHAR_LOWER_N;
         n = 2;
      end else if (c == jse_pkg::CHAR_CR) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = jse_pkg::CHAR_LOWER_R;
         n = 2;
      end else if (c == jse_pkg::CHAR_TAB) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = jse_pkg::CHAR_LOWER_T;
         n = 2;
      end else if (c < jse_pkg::CHAR_SPACE) begin
         // \u00xx, cut short so the terminator still fits
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = jse_pkg::CHAR_LOWER_U;
         seq[2] = jse_pkg::CHAR_ZERO;
         seq[3] = jse_pkg::CHAR_ZERO;
         seq[4] = hex_digit(c[7:4]);
         seq[5] = hex_digit(c[3:0]);
         room = int'(capacity_shadow) - 1 - int'(count_shadow);
         n = (room < 6) ? room : 6;
      end else begin
         seq[0] = c;
         n = 1;
      end
      for (i = 0; i < n; i++) begin
         pending_escapes.push_back('{ch: seq[i], last: (i == n - 1), eos: 1'b0});
      end
      count_shadow = count_shadow + 16'(n);
   endfunction

   // monitor: predicts on each accepted request, checks each accepted result,
   // and tracks csr writes so the predictor sees the same capacity
   always @(posedge clock) begin
      esc_byte_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready &&
             paddr == {jse_pkg::REG_OUT_CAPACITY, 2'b00}) begin
            capacity_shadow = pwdata[15:0];
            capacity_writes++;
         end
         if (req_valid && req_ready) begin
            predict_escape(req_in_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_escapes.size() == 0) begin
               $error("unexpected result: out_byte %02h last %0b eos %0b",
                      rsp_out_byte, rsp_last_of_run, rsp_end_of_string);
               error_count++;
            end else begin
               want = pending_escapes.pop_front();
               results_checked++;
               if (rsp_out_byte !== want.ch) begin
                  $error("out_byte: expected %02h, got %02h", want.ch, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
                  error_count++;
               end
               if (rsp_end_of_string !== want.eos) begin
                  $error("end_of_string: expected %0b, got %0b",
                         want.eos, rsp_end_of_string);
                  error_count++;
               end
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!rsp_stalls_on || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
      end
   end

   // watchdog: any handshake or csr access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_escapes.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // offer one request and hold it until taken; valid stays up when no gap follows,
   // so the caller must send again or drain in the same step
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sent_requests++;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every expected result, then let any dropped request settle
   // the first edge lets the monitor log a request taken at the edge we return on
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_escapes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // setup cycle then access cycle; only called with the block idle
   task automatic write_capacity(input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {jse_pkg::REG_OUT_CAPACITY, 2'b00};
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // every escape class and the byte extremes at the reset capacity
   task automatic test_escape_classes();
      send_byte(jse_pkg::CHAR_QUOTE);
      send_byte(jse_pkg::CHAR_BACKSLASH);
      send_byte(jse_pkg::CHAR_LF);
      send_byte(jse_pkg::CHAR_CR);
      send_byte(jse_pkg::CHAR_TAB);
      send_byte(8'h01);
      send_byte(8'h1F);
      send_byte(jse_pkg::CHAR_SPACE);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(jse_pkg::CHAR_NUL);
      // empty string
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
   endtask

   // a unicode escape that only partly fits, and a capacity with no room at all
   task automatic test_truncated_unicode();
      write_capacity(16'd6);
      send_byte(8'h01);
      send_byte(8'h41);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
      write_capacity(16'd4);
      send_byte(8'h1B);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
      write_capacity(16'd2);
      send_byte(8'h41);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
   endtask

   // capacity below two takes no characters but still terminates
   task automatic test_tiny_capacity();
      write_capacity(16'd0);
      send_byte(8'h41);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
      write_capacity(16'd1);
      send_byte(8'h05);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
   endtask

   // shrink the buffer under an open string, then the widest setting
   task automatic test_capacity_lowered();
      int k;
      write_capacity(jse_pkg::CAPACITY_RESET);
      for (k = 0; k < 8; k++) begin
         send_byte(8'h78);
      end
      drain_results();
      write_capacity(16'd5);
      send_byte(8'h79);
      send_byte(8'h01);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
      write_capacity(16'hFFFF);
      send_byte(jse_pkg::CHAR_QUOTE);
      send_byte(8'h0C);
      send_byte(jse_pkg::CHAR_NUL);
      drain_results();
   endtask

   function automatic logic [7:0] random_string_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 8'($urandom_range(8'h20, 8'h7E));
      end else if (r < 55) begin
         case ($urandom_range(0, 4))
            0: return jse_pkg::CHAR_QUOTE;
            1: return jse_pkg::CHAR_BACKSLASH;
            2: return jse_pkg::CHAR_LF;
            3: return jse_pkg::CHAR_CR;
            default: return jse_pkg::CHAR_TAB;
         endcase
      end else if (r < 70) begin
         return 8'($urandom_range(8'h01, 8'h1F));
      end else if (r < 90) begin
         return 8'($urandom_range(8'h80, 8'hFF));
      end
      // anything at all, a stray zero ends the string early
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] random_capacity();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         return 16'($urandom_range(2, 24));
      end else if (r < 7) begin
         return 16'($urandom_range(25, 300));
      end else if (r == 7) begin
         return 16'hFFFF;
      end else if (r == 8) begin
         return 16'($urandom_range(2, 65535));
      end
      return jse_pkg::CAPACITY_RESET;
   endfunction

   // random strings in phases, each phase under its own capacity
   task automatic test_random_strings();
      int start_count;
      int phase_strings;
      int len;
      int s;
      int k;
      start_count = sent_requests;
      while (sent_requests - start_count < RANDOM_TARGET) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         write_capacity(random_capacity());
         phase_strings = $urandom_range(2, 6);
         for (s = 0; s < phase_strings; s++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
            for (k = 0; k < len; k++) begin
               send_byte(random_string_byte());
            end
            // now and then a string stays open across the next capacity change
            if ($urandom_range(0, 9) != 0) begin
               send_byte(jse_pkg::CHAR_NUL);
            end
         end
         drain_results();
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escape_classes();
      test_truncated_unicode();
      test_tiny_capacity();
      test_capacity_lowered();
      test_random_strings();
      drain_results();
      if (pending_escapes.size() != 0) begin
         $error("%0d expected results never arrived", pending_escapes.size());
         error_count++;
      end
      $display("covered %0d consumed and %0d dropped requests, %0d strings ended",
               useful_requests, dropped_requests, strings_ended);
      $display("checked %0d escaped bytes across %0d capacity settings, %0d mismatches",
               results_checked, capacity_writes, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escape.sv
verif/json_string_escape_tb.sv
